FILE: rtl/wau_pkg.sv
// ----------------------------------------------------------------------------
// wau_pkg
// Shared types, constants and mod-360 helpers for the wheel angle unwrap block.
// ----------------------------------------------------------------------------
package wau_pkg;

    localparam int NUM_WHEELS = 4;

    localparam int IDX_W    = 2;
    localparam int RAW_W    = 16;
    localparam int OFS_W    = 10;
    localparam int CFG_W    = 15;
    localparam int STEP_W   = 10;
    localparam int DEG_W    = 9;
    localparam int FOLD_W   = 17;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam int DEG_MOD  = 360;
    localparam int DEG_HALF = 180;
    localparam int OFS_MAX  = 359;

    // 360 * 93, lifts raw + offset into a non-negative 17-bit value
    localparam int FOLD_BIAS = 33480;

    localparam logic [CFG_W-1:0]  WRAP_THRESHOLD_RESET = 15'd13000;
    localparam logic [CFG_W-1:0]  RAW_LIMIT_RESET      = 15'd13602;
    localparam logic [STEP_W-1:0] STEP_RESET           = 10'd564;

    typedef enum logic [0:0] {
        REG_WRAP_THRESHOLD = 1'b0,
        REG_RAW_LIMIT      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]  wrap_threshold;
        logic [STEP_W-1:0] step;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [FOLD_W-1:0] value;
    } fold_req_t;

    // (i * 512) mod 360 for the upper 8 bits of a folded value
    typedef logic [255:0][8:0] mod_tab_t;

    function automatic mod_tab_t build_mod_tab();
        mod_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 9'((i * 512) % DEG_MOD);
        end
        return t;
    endfunction

    localparam mod_tab_t MOD_TAB = build_mod_tab();

    // reduce a value below 3*360 to 0..359
    function automatic logic [8:0] mod360_small(input logic [9:0] s);
        logic [9:0] r;
        if (s >= 10'd720)
        begin
            r = s - 10'd720;
        end
        else if (s >= 10'd360)
        begin
            r = s - 10'd360;
        end
        else
        begin
            r = s;
        end
        return r[8:0];
    endfunction

endpackage

FILE: rtl/wau_cfg.sv
// ----------------------------------------------------------------------------
// wau_cfg
// APB register file: wrap threshold and raw limit, plus the derived offset step.
// ----------------------------------------------------------------------------
module wau_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [wau_pkg::ADDR_W-1:0] paddr,
    input  logic [wau_pkg::DATA_W-1:0] pwdata,
    output logic [wau_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output wau_pkg::cfg_t             cfg
);
    import wau_pkg::*;

    logic [CFG_W-1:0]  thr_reg;
    logic [CFG_W-1:0]  lim_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [9:0]        lim_sum;
    logic [8:0]        lim_mod;
    logic              wr_en;
    reg_idx_t          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[2]);

    // limit mod 360 from a 512-chunk table, step is twice that
    assign lim_sum   = {1'b0, MOD_TAB[{2'b00, pwdata[14:9]}]} + {1'b0, pwdata[8:0]};
    assign lim_mod   = mod360_small(lim_sum);
    assign step_next = {lim_mod, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= WRAP_THRESHOLD_RESET;
            lim_reg  <= RAW_LIMIT_RESET;
            step_reg <= STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_WRAP_THRESHOLD:
                begin
                    thr_reg <= pwdata[CFG_W-1:0];
                end
                REG_RAW_LIMIT:
                begin
                    lim_reg  <= pwdata[CFG_W-1:0];
                    step_reg <= step_next;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WRAP_THRESHOLD: prdata = {{(DATA_W-CFG_W){1'b0}}, thr_reg};
            REG_RAW_LIMIT:      prdata = {{(DATA_W-CFG_W){1'b0}}, lim_reg};
        endcase
    end

    assign cfg.wrap_threshold = thr_reg;
    assign cfg.step           = step_reg;

endmodule

FILE: rtl/wau_track.sv
// ----------------------------------------------------------------------------
// wau_track
// Per-wheel state memory with read-modify-write, write forwarding and
// wrap detection; hands the biased angle sum to the fold stage.
// ----------------------------------------------------------------------------
module wau_track (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wau_pkg::cfg_t              cfg,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic [wau_pkg::IDX_W-1:0]  wheel_index,
    input  logic [wau_pkg::RAW_W-1:0]  raw_angle,
    output wau_pkg::fold_req_t         fold_req,
    input  logic                       fold_stall
);
    import wau_pkg::*;

    localparam int ENTRY_W = RAW_W + OFS_W;

    logic [ENTRY_W-1:0]    mem [NUM_WHEELS];
    logic [ENTRY_W-1:0]    rdata_reg;
    logic [NUM_WHEELS-1:0] vld_reg;

    logic                  v1_reg;
    logic [IDX_W-1:0]      idx1_reg;
    logic [RAW_W-1:0]      raw1_reg;

    logic                  wb_v_reg;
    logic [IDX_W-1:0]      wb_idx_reg;
    logic [ENTRY_W-1:0]    wb_data_reg;

    logic                  v2_reg;
    logic [FOLD_W-1:0]     val2_reg;

    logic                  en1;
    logic                  en2;
    logic                  accept;
    logic                  in_range;
    logic                  wr_en;
    logic [ENTRY_W-1:0]    entry;
    logic [RAW_W-1:0]      prev;
    logic [OFS_W-1:0]      ofs_old;
    logic [OFS_W-1:0]      ofs_upd;
    logic [OFS_W-1:0]      ofs_new;
    logic signed [16:0]    raw_s;
    logic signed [16:0]    prev_s;
    logic signed [16:0]    thr_s;
    logic signed [16:0]    thr_neg;
    logic signed [11:0]    ofs_plus;
    logic signed [11:0]    ofs_minus;
    logic                  wrap_fwd;
    logic                  wrap_bwd;
    logic [17:0]           sum;

    assign en2          = !v2_reg || !fold_stall;
    assign en1          = !v1_reg || en2;
    assign sample_stall = !en1;
    assign accept       = sample_valid && en1;

    assign in_range = (32'(idx1_reg) < NUM_WHEELS);
    assign wr_en    = v1_reg && en2 && in_range;

    // latest write wins over the memory read, unwritten entries read as zero
    always_comb
    begin
        priority if (wb_v_reg && (wb_idx_reg == idx1_reg))
        begin
            entry = wb_data_reg;
        end
        else if (vld_reg[idx1_reg])
        begin
            entry = rdata_reg;
        end
        else
        begin
            entry = '0;
        end
    end

    assign prev    = entry[ENTRY_W-1:OFS_W];
    assign ofs_old = entry[OFS_W-1:0];

    assign raw_s   = {raw1_reg[RAW_W-1], raw1_reg};
    assign prev_s  = {prev[RAW_W-1], prev};
    assign thr_s   = {2'b00, cfg.wrap_threshold};
    assign thr_neg = -thr_s;

    assign wrap_fwd = (raw_s < thr_neg) && (prev_s > thr_s);
    assign wrap_bwd = (prev_s < thr_neg) && (raw_s > thr_s);

    assign ofs_plus  = {{2{ofs_old[OFS_W-1]}}, ofs_old} + {2'b00, cfg.step};
    assign ofs_minus = {{2{ofs_old[OFS_W-1]}}, ofs_old} - {2'b00, cfg.step};

    // truncating remainder by 360 on a sum that stays within three turns
    always_comb
    begin
        priority if (wrap_fwd)
        begin
            priority if (ofs_plus >= 12'sd720)
            begin
                ofs_upd = OFS_W'(ofs_plus - 12'sd720);
            end
            else if (ofs_plus >= 12'sd360)
            begin
                ofs_upd = OFS_W'(ofs_plus - 12'sd360);
            end
            else
            begin
                ofs_upd = OFS_W'(ofs_plus);
            end
        end
        else if (wrap_bwd)
        begin
            priority if (ofs_minus <= -12'sd720)
            begin
                ofs_upd = OFS_W'(ofs_minus + 12'sd720);
            end
            else if (ofs_minus <= -12'sd360)
            begin
                ofs_upd = OFS_W'(ofs_minus + 12'sd360);
            end
            else
            begin
                ofs_upd = OFS_W'(ofs_minus);
            end
        end
        else
        begin
            ofs_upd = ofs_old;
        end
    end

    assign ofs_new = in_range ? ofs_upd : '0;

    assign sum = {{2{raw1_reg[RAW_W-1]}}, raw1_reg}
               + {{8{ofs_new[OFS_W-1]}}, ofs_new}
               + 18'(FOLD_BIAS);

    // state memory: read at accept, write back as the item leaves stage one
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= mem[wheel_index];
        end
        if (wr_en)
        begin
            mem[idx1_reg] <= {raw1_reg, ofs_new};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            wb_v_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= sample_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (wr_en)
            begin
                wb_v_reg          <= 1'b1;
                vld_reg[idx1_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx1_reg <= wheel_index;
            raw1_reg <= raw_angle;
        end
        if (wr_en)
        begin
            wb_idx_reg  <= idx1_reg;
            wb_data_reg <= {raw1_reg, ofs_new};
        end
        if (en2 && v1_reg)
        begin
            val2_reg <= sum[FOLD_W-1:0];
        end
    end

    assign fold_req.valid = v2_reg;
    assign fold_req.value = val2_reg;

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> vld_reg[$past(idx1_reg)])
        else $error("written entry not marked valid");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (($signed(ofs_new) <= OFS_MAX) && ($signed(ofs_new) >= -OFS_MAX)))
        else $error("degree offset out of range");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(idx1_reg) && $stable(raw1_reg)))
        else $error("stalled stage one item changed");

endmodule

FILE: rtl/wau_fold.sv
// ----------------------------------------------------------------------------
// wau_fold
// Reduces the biased angle sum mod 360, centers it on zero and holds the
// result request in the output register.
// ----------------------------------------------------------------------------
module wau_fold (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wau_pkg::fold_req_t         fold_req,
    output logic                       fold_stall,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [wau_pkg::DEG_W-1:0]  wheel_angle_deg
);
    import wau_pkg::*;

    logic             out_v_reg;
    logic [DEG_W-1:0] deg_reg;
    logic [DEG_W-1:0] deg_next;
    logic             en_out;
    logic [9:0]       chunk_sum;
    logic [8:0]       rem;
    logic [9:0]       centered;

    assign en_out     = !out_v_reg || !result_stall;
    assign fold_stall = !en_out;

    // value = hi * 512 + lo, hi taken mod 360 from the table
    assign chunk_sum = {1'b0, MOD_TAB[fold_req.value[FOLD_W-1:9]]}
                     + {1'b0, fold_req.value[8:0]};
    assign rem       = mod360_small(chunk_sum);
    assign centered  = {1'b0, rem} - 10'(DEG_HALF);
    assign deg_next  = centered[DEG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_v_reg <= fold_req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && fold_req.valid)
        begin
            deg_reg <= deg_next;
        end
    end

    assign result_valid    = out_v_reg;
    assign wheel_angle_deg = deg_reg;

    a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (($signed(deg_reg) >= -DEG_HALF) && ($signed(deg_reg) < DEG_HALF)))
        else $error("angle out of range");

    a_request_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (en_out && fold_req.valid) |=> out_v_reg)
        else $error("fold request lost");

endmodule

FILE: rtl/wheel_angle_unwrap_top.sv
// Pipeline: stage one, stage two, output register; a result stall can hold each stage.
// Throughput: one sample per cycle when not stalled; per-wheel state is read at accept
// and is written back as it leaves stage one; write forwarding covers the overlap.
// Reset: wrap_threshold = 13000, raw_limit = 13602; per-wheel valid bits clear so every
// wheel starts at raw count 0 and offset 0; no memory clearing pass.
// ----------------------------------------------------------------------------
// wheel_angle_unwrap_top
// Multi-turn wheel angle unwrap for up to four wheels, APB configured.
// ----------------------------------------------------------------------------
module wheel_angle_unwrap_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wau_pkg::ADDR_W-1:0] paddr,
    input  logic [wau_pkg::DATA_W-1:0] pwdata,
    output logic [wau_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic [wau_pkg::IDX_W-1:0]  wheel_index,
    input  logic [wau_pkg::RAW_W-1:0]  raw_angle,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [wau_pkg::DEG_W-1:0]  wheel_angle_deg
);
    import wau_pkg::*;

    cfg_t      cfg;
    fold_req_t fold_req;
    logic      fold_stall;

    wau_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wau_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .wheel_index  (wheel_index),
        .raw_angle    (raw_angle),
        .fold_req     (fold_req),
        .fold_stall   (fold_stall)
    );

    wau_fold u_fold (
        .clk             (clk),
        .rst_n           (rst_n),
        .fold_req        (fold_req),
        .fold_stall      (fold_stall),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .wheel_angle_deg (wheel_angle_deg)
    );

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the wheel angle unwrap block: a short table of directed samples and
// then random per-wheel counter walks, with noise, over several register
// settings; each result is compared in order with a testbench-computed angle.
// ----------------------------------------------------------------------------
module tb;
    import wau_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [IDX_W-1:0]    wheel_index = '0;
    logic [RAW_W-1:0]    raw_angle = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [DEG_W-1:0]    wheel_angle_deg;

    typedef struct {
        logic [IDX_W-1:0] wheel;
        logic [RAW_W-1:0] raw;
        logic [DEG_W-1:0] deg;
    } angle_exp_t;

    typedef struct {
        logic [IDX_W-1:0] wheel;
        int               raw;
        bit               fixed;
        int               deg;
    } sample_row_t;

    typedef struct {
        int thresh;
        int limit;
    } cfg_set_t;

    angle_exp_t angle_q[$];

    // predictor state
    int                 thresh_cfg = 13000;
    int                 limit_cfg = 13602;
    logic signed [15:0] prev_raw [NUM_WHEELS];
    int                 turn_ofs [NUM_WHEELS];

    // stimulus state
    int err_count = 0;
    int burst_left = 0;
    int walk_pos [NUM_WHEELS];
    int walk_dir [NUM_WHEELS];
    int stall_mode = 0;
    int stall_run = 0;

    wheel_angle_unwrap_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .wheel_index     (wheel_index),
        .raw_angle       (raw_angle),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .wheel_angle_deg (wheel_angle_deg)
    );

    always #5 clk = ~clk;

    task automatic report(input string what);
        if (err_count < 40)
        begin
            $display("tb: mismatch: %s", what);
        end
        err_count++;
    endtask

    // advances the wheel state and returns the angle the block must produce
    function automatic logic [DEG_W-1:0] unwrap_angle(input logic [IDX_W-1:0] w,
                                                      input logic [RAW_W-1:0] raw_bits);
        int r;
        int p;
        int ofs;
        int step;
        int ang;
        r = $signed(raw_bits);
        ofs = 0;
        if (int'(w) < NUM_WHEELS)
        begin
            p = prev_raw[w];
            step = 2 * (limit_cfg % DEG_MOD);
            ofs = turn_ofs[w];
            prev_raw[w] = raw_bits;
            if (r < -thresh_cfg && p > thresh_cfg)
            begin
                ofs = (ofs + step) % DEG_MOD;
            end
            else if (p < -thresh_cfg && r > thresh_cfg)
            begin
                ofs = (ofs - step) % DEG_MOD;
            end
            turn_ofs[w] = ofs;
        end
        ang = (r + ofs) % DEG_MOD;
        if (ang < 0)
        begin
            ang += DEG_MOD;
        end
        ang -= DEG_HALF;
        return ang[DEG_W-1:0];
    endfunction

    task automatic cfg_write(input reg_idx_t idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WRAP_THRESHOLD: thresh_cfg = value & 32'h7fff;
            REG_RAW_LIMIT:      limit_cfg = value & 32'h7fff;
            default:            ;
        endcase
    endtask

    // hold a request until it is taken, then queue its angle
    task automatic send_sample(input logic [IDX_W-1:0] w, input logic [RAW_W-1:0] raw,
                               input bit fixed, input int fixed_deg);
        logic [DEG_W-1:0] deg;
        sample_valid <= 1'b1;
        wheel_index <= w;
        raw_angle <= raw;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        deg = unwrap_angle(w, raw);
        if (fixed)
        begin
            deg = fixed_deg[DEG_W-1:0];
        end
        angle_q.push_back('{w, raw, deg});
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic drain;
        sample_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (angle_q.size() != 0);
    endtask

    // mostly counter-like walks that wrap at the raw limit, some noise
    task automatic send_random;
        logic [IDX_W-1:0] w;
        int lim;
        int span;
        w = $urandom_range(0, NUM_WHEELS - 1);
        if ($urandom_range(0, 3) == 0)
        begin
            send_sample(w, RAW_W'($urandom_range(0, 65535)), 1'b0, 0);
        end
        else
        begin
            lim = (limit_cfg == 0) ? 32767 : limit_cfg;
            span = ($urandom_range(0, 1) == 0) ? lim / 20 + 1 : lim / 3 + 1;
            if ($urandom_range(0, 15) == 0)
            begin
                walk_dir[w] = -walk_dir[w];
            end
            if (walk_pos[w] > lim)
            begin
                walk_pos[w] = lim;
            end
            else if (walk_pos[w] < -lim)
            begin
                walk_pos[w] = -lim;
            end
            walk_pos[w] += walk_dir[w] * int'($urandom_range(0, span));
            if (walk_pos[w] > lim)
            begin
                walk_pos[w] -= 2 * lim + 1;
            end
            else if (walk_pos[w] < -lim)
            begin
                walk_pos[w] += 2 * lim + 1;
            end
            send_sample(w, RAW_W'(walk_pos[w]), 1'b0, 0);
        end
    endtask

    // receiver stall pattern: runs of no stall, light stall and heavy stall
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_run = $urandom_range(5, 40);
        end
        else
        begin
            stall_run--;
        end
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 2) == 0);
            default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (angle_q.size() == 0)
            begin
                report($sformatf("unexpected angle %0d", $signed(wheel_angle_deg)));
            end
            else
            begin
                if (wheel_angle_deg !== angle_q[0].deg)
                begin
                    report($sformatf("wheel %0d raw %0d: angle %0d, want %0d",
                                     angle_q[0].wheel, $signed(angle_q[0].raw),
                                     $signed(wheel_angle_deg), $signed(angle_q[0].deg)));
                end
                void'(angle_q.pop_front());
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        sample_row_t rows[$];
        cfg_set_t    phases[$];
        int          pause_at;

        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            prev_raw[i] = '0;
            turn_ofs[i] = 0;
            walk_pos[i] = 0;
            walk_dir[i] = (i % 2 == 0) ? 1 : -1;
        end

        // after reset every wheel sits at count 0 and offset 0
        rows = '{
            '{2'd0, 0,      1'b1, -180},
            '{2'd1, 32767,  1'b1, -173},
            '{2'd2, -32768, 1'b1, 172},
            '{2'd3, 180,    1'b1, 0},
            '{2'd3, 179,    1'b1, -1},
            '{2'd1, -32768, 1'b0, 0},
            '{2'd1, 32767,  1'b0, 0},
            '{2'd0, 13001,  1'b0, 0},
            '{2'd0, -13001, 1'b0, 0},
            '{2'd0, 13000,  1'b0, 0},
            '{2'd0, -13000, 1'b0, 0},
            '{2'd0, 13602,  1'b0, 0},
            '{2'd0, -13602, 1'b0, 0},
            '{2'd0, 13602,  1'b0, 0},
            '{2'd2, 0,      1'b0, 0},
            '{2'd2, 13602,  1'b0, 0},
            '{2'd2, -13602, 1'b0, 0},
            '{2'd2, 5000,   1'b0, 0},
            '{2'd2, 13602,  1'b0, 0},
            '{2'd2, -13602, 1'b0, 0},
            '{2'd3, -1,     1'b0, 0},
            '{2'd3, 21845,  1'b0, 0},
            '{2'd3, -21846, 1'b0, 0},
            '{2'd1, -360,   1'b0, 0}
        };

        // reset values again, threshold extremes, limit extremes, zero step
        phases = '{
            '{13000, 13602},
            '{0,     32767},
            '{32767, 1},
            '{500,   0},
            '{0,     1},
            '{9000,  9180}
        };
        phases.push_back('{$urandom_range(0, 32767), $urandom_range(0, 32767)});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_sample(rows[i].wheel, RAW_W'(rows[i].raw), rows[i].fixed, rows[i].deg);
        end
        drain();

        foreach (phases[p])
        begin
            cfg_write(REG_WRAP_THRESHOLD, phases[p].thresh);
            cfg_write(REG_RAW_LIMIT, phases[p].limit);
            pause_at = $urandom_range(10, 80);
            for (int n = 0; n < 90; n++)
            begin
                if (n == pause_at)
                begin
                    drain();
                end
                send_random();
            end
            drain();
        end

        repeat (6) @(posedge clk);
        if (err_count == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/wau_pkg.sv
rtl/wau_cfg.sv
rtl/wau_track.sv
rtl/wau_fold.sv
rtl/wheel_angle_unwrap_top.sv
tb/tb.sv
